// ===== src/ptls_pkg.sv =====
`default_nettype none
package ptls_pkg;

  localparam int MAX_LANDMARKS_DEF = 256;
  localparam int SUM_WIDTH_DEF = 64;

  localparam int CFG_W = 16;
  localparam int PU_W = 9;
  localparam int MIN_POINTS = 3;
  localparam int DIV_STEPS = 128;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ROUND_HALF = 8192;

  localparam logic [CFG_W-1:0] FOCAL_X_RST = 16'd16384;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST = 16'd16384;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 16'd10240;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 16'd7680;

  localparam logic [31:0] INT32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FUNC_ROT = 1'b0,
    FUNC_LMK = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FEW      = 2'd1,
    STATUS_SINGULAR = 2'd2,
    STATUS_BEHIND   = 2'd3
  } status_t;

  // normal sum slots
  localparam logic [2:0] SUM_U   = 3'd0;
  localparam logic [2:0] SUM_V   = 3'd1;
  localparam logic [2:0] SUM_UU  = 3'd2;
  localparam logic [2:0] SUM_VV  = 3'd3;
  localparam logic [2:0] SUM_B1  = 3'd4;
  localparam logic [2:0] SUM_B2  = 3'd5;
  localparam logic [2:0] SUM_UB  = 3'd6;
  localparam int NUM_SUMS = 7;

  localparam int OP_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_R0, OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_R6, OP_R7, OP_R8,
    OP_B1_A, OP_B1_B, OP_B2_A, OP_B2_B,
    OP_UU, OP_VV, OP_UB1, OP_VB2,
    OP_S6, OP_S0, OP_S1, OP_S4, OP_S5,
    OP_D_SUM, OP_D_N, OP_D_U, OP_D_V,
    OP_NZ_U, OP_NZ_V, OP_NZ_N,
    OP_X_T, OP_X_D, OP_Y_T, OP_Y_D
  } op_t;

  typedef struct packed {
    logic               func;
    logic [1:0]         rot_row;
    logic signed [15:0] rot_c0;
    logic signed [15:0] rot_c1;
    logic signed [15:0] rot_c2;
    logic signed [15:0] obj_x;
    logic signed [15:0] obj_y;
    logic signed [15:0] obj_z;
    logic [15:0]        img_u;
    logic [15:0]        img_v;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic [1:0]         status;
    logic [PU_W-1:0]    points_used;
  } out_item_t;

  // column of the model point used by a rotation step
  function automatic logic [1:0] rot_col(input op_t op);
    logic [1:0] c;
    case (op)
      OP_R0, OP_R3, OP_R6: c = 2'd0;
      OP_R1, OP_R4, OP_R7: c = 2'd1;
      default:             c = 2'd2;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/pose_translation_least_squares_top.sv =====
// a rotation row beat is stored and leaves the block idle; a landmark beat, unless the
// count is full, runs 17 products through the shared shift-add multiplier (each until the
// magnitude of its second operand is shifted out) and 5 sum updates
// the last landmark adds the solve: 64-bit products for the determinant and z, x and y terms
// and three 128-step serial divisions. one item at a time; in_ready is high only when idle
// reset (rst_n low, synchronous): sums, count and rotation rows clear, registers take defaults
`default_nettype none
module pose_translation_least_squares_top #(
  parameter int MAX_LANDMARKS = ptls_pkg::MAX_LANDMARKS_DEF,
  parameter int SUM_WIDTH = ptls_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire ptls_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      ptls_pkg::out_item_t out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  localparam int CW = $clog2(MAX_LANDMARKS + 1);
  localparam int SW = SUM_WIDTH;
  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_MUL_LD   = 10'b0000000010,
    ST_MUL_RUN  = 10'b0000000100,
    ST_POST     = 10'b0000001000,
    ST_CHECK    = 10'b0000010000,
    ST_DIV_NEG  = 10'b0000100000,
    ST_DIV_PRE  = 10'b0001000000,
    ST_DIV_RUN  = 10'b0010000000,
    ST_DIV_POST = 10'b0100000000,
    ST_OUT      = 10'b1000000000
  } state_t;

  state_t st_r, st_nxt;
  ptls_pkg::op_t op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [SW-1:0] sums_r [ptls_pkg::NUM_SUMS];
  logic signed [SW-1:0] sums_nxt [ptls_pkg::NUM_SUMS];
  logic signed [15:0] rot_r [9];
  logic signed [15:0] rot_nxt [9];
  logic [15:0] fx_r, fx_nxt, fy_r, fy_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [15:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic signed [16:0] u_r, u_nxt, v_r, v_nxt;
  logic last_r, last_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic signed [19:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic signed [63:0] b1_r, b1_nxt, b2_r, b2_nxt, t_r, t_nxt, tmp_r, tmp_nxt, d_r, d_nxt;
  logic [127:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt;
  logic signed [31:0] tz_r, tz_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  ptls_pkg::status_t status_r, status_nxt;
  logic [127:0] mul_a_r, mul_a_nxt, mul_p_r, mul_p_nxt;
  logic [63:0] mul_b_r, mul_b_nxt;
  logic [127:0] dv_mag_r, dv_mag_nxt;
  logic [63:0] dv_rem_r, dv_rem_nxt, dv_q_r, dv_q_nxt;
  logic dv_big_r, dv_big_nxt, dv_neg_r, dv_neg_nxt;
  logic [ptls_pkg::DIV_CNT_W-1:0] dv_cnt_r, dv_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  ptls_pkg::out_item_t out_data_r, out_data_nxt;

  logic signed [63:0] su, sv, s2, s3, s4, s5, s6, n64, r64;
  logic signed [63:0] mul_a_s, mul_b_s, d_tmp;
  logic [127:0] a128;
  logic [1:0] col;
  logic signed [33:0] acc_sum, rnd;
  logic sa_en;
  logic [2:0] sa_idx;
  logic signed [63:0] sa_term;
  logic signed [SW-1:0] sa_cur, sa_tc, sa_res;
  logic [SW:0] sa_wide;
  logic [63:0] dv_den, rem_sh;
  logic signed [31:0] dv_res;
  logic in_acc, out_load;

  assign in_ready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign in_acc = in_valid && in_ready;
  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_ready);

  assign su = 64'(sums_r[ptls_pkg::SUM_U]);
  assign sv = 64'(sums_r[ptls_pkg::SUM_V]);
  assign s2 = 64'(sums_r[ptls_pkg::SUM_UU]);
  assign s3 = 64'(sums_r[ptls_pkg::SUM_VV]);
  assign s4 = 64'(sums_r[ptls_pkg::SUM_B1]);
  assign s5 = 64'(sums_r[ptls_pkg::SUM_B2]);
  assign s6 = 64'(sums_r[ptls_pkg::SUM_UB]);
  assign n64 = 64'(cnt_r);
  assign r64 = mul_p_r[63:0];
  assign col = ptls_pkg::rot_col(op_r);
  assign dv_den = {den_r[62:0], 1'b0};
  assign rem_sh = {dv_rem_r[62:0], dv_mag_r[127]};

  // operands of the shared multiplier
  always_comb begin
    mul_a_s = '0;
    mul_b_s = '0;
    case (op_r)
      ptls_pkg::OP_R0, ptls_pkg::OP_R1, ptls_pkg::OP_R2,
      ptls_pkg::OP_R3, ptls_pkg::OP_R4, ptls_pkg::OP_R5,
      ptls_pkg::OP_R6, ptls_pkg::OP_R7, ptls_pkg::OP_R8: begin
        mul_a_s = 64'(rot_r[op_r[3:0]]);
        case (col)
          2'd0:    mul_b_s = 64'(ox_r);
          2'd1:    mul_b_s = 64'(oy_r);
          default: mul_b_s = 64'(oz_r);
        endcase
      end
      ptls_pkg::OP_B1_A: begin mul_a_s = 64'(u_r); mul_b_s = 64'(pz_r); end
      ptls_pkg::OP_B1_B: begin mul_a_s = $signed(64'(fx_r)); mul_b_s = 64'(px_r); end
      ptls_pkg::OP_B2_A: begin mul_a_s = 64'(v_r); mul_b_s = 64'(pz_r); end
      ptls_pkg::OP_B2_B: begin mul_a_s = $signed(64'(fy_r)); mul_b_s = 64'(py_r); end
      ptls_pkg::OP_UU:   begin mul_a_s = 64'(u_r); mul_b_s = 64'(u_r); end
      ptls_pkg::OP_VV:   begin mul_a_s = 64'(v_r); mul_b_s = 64'(v_r); end
      ptls_pkg::OP_UB1:  begin mul_a_s = 64'(u_r); mul_b_s = b1_r; end
      ptls_pkg::OP_VB2:  begin mul_a_s = 64'(v_r); mul_b_s = b2_r; end
      ptls_pkg::OP_D_N:  begin mul_a_s = n64; mul_b_s = tmp_r; end
      ptls_pkg::OP_D_U:  begin mul_a_s = su; mul_b_s = su; end
      ptls_pkg::OP_D_V:  begin mul_a_s = sv; mul_b_s = sv; end
      ptls_pkg::OP_NZ_U: begin mul_a_s = su; mul_b_s = s4; end
      ptls_pkg::OP_NZ_V: begin mul_a_s = sv; mul_b_s = s5; end
      ptls_pkg::OP_NZ_N: begin mul_a_s = n64; mul_b_s = s6; end
      ptls_pkg::OP_X_T:  begin mul_a_s = su; mul_b_s = 64'(tz_r); end
      ptls_pkg::OP_X_D:  begin mul_a_s = n64; mul_b_s = $signed(64'(fx_r)); end
      ptls_pkg::OP_Y_T:  begin mul_a_s = sv; mul_b_s = 64'(tz_r); end
      ptls_pkg::OP_Y_D:  begin mul_a_s = n64; mul_b_s = $signed(64'(fy_r)); end
      default: begin mul_a_s = '0; mul_b_s = '0; end
    endcase
  end

  // sum term selection and saturating add
  always_comb begin
    sa_en = 1'b0;
    sa_idx = ptls_pkg::SUM_U;
    sa_term = '0;
    if (st_r == ST_POST) begin
      case (op_r)
        ptls_pkg::OP_UU: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_UU; sa_term = r64; end
        ptls_pkg::OP_VV: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_VV; sa_term = r64; end
        ptls_pkg::OP_S6: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_UB; sa_term = t_r; end
        ptls_pkg::OP_S0: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_U; sa_term = 64'(u_r); end
        ptls_pkg::OP_S1: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_V; sa_term = 64'(v_r); end
        ptls_pkg::OP_S4: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_B1; sa_term = b1_r; end
        ptls_pkg::OP_S5: begin sa_en = 1'b1; sa_idx = ptls_pkg::SUM_B2; sa_term = b2_r; end
        default: sa_en = 1'b0;
      endcase
    end
    sa_cur = sums_r[sa_idx];
    if ((&sa_term[63:SW-1]) || !(|sa_term[63:SW-1])) begin
      sa_tc = sa_term[SW-1:0];
    end else begin
      sa_tc = sa_term[63] ? SMIN : SMAX;
    end
    sa_wide = {sa_cur[SW-1], sa_cur} + {sa_tc[SW-1], sa_tc};
    if (sa_wide[SW] != sa_wide[SW-1]) begin
      sa_res = sa_wide[SW] ? SMIN : SMAX;
    end else begin
      sa_res = sa_wide[SW-1:0];
    end
  end

  // rounded, saturated quotient of the serial divider
  always_comb begin
    if (dv_neg_r) begin
      if (dv_big_r || dv_q_r > 64'(ptls_pkg::INT32_MIN)) dv_res = ptls_pkg::INT32_MIN;
      else dv_res = -$signed(dv_q_r[31:0]);
    end else begin
      if (dv_big_r || dv_q_r > 64'(ptls_pkg::INT32_MAX)) dv_res = ptls_pkg::INT32_MAX;
      else dv_res = $signed(dv_q_r[31:0]);
    end
  end

  assign acc_sum = ((col == 2'd0) ? 34'sd0 : acc_r) + $signed(mul_p_r[33:0]);
  assign rnd = acc_sum + 34'(ptls_pkg::ROUND_HALF);
  assign d_tmp = d_r - r64;
  assign a128 = 128'(mul_a_s);

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    sums_nxt = sums_r;
    rot_nxt = rot_r;
    fx_nxt = fx_r;
    fy_nxt = fy_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    oz_nxt = oz_r;
    u_nxt = u_r;
    v_nxt = v_r;
    last_nxt = last_r;
    acc_nxt = acc_r;
    px_nxt = px_r;
    py_nxt = py_r;
    pz_nxt = pz_r;
    b1_nxt = b1_r;
    b2_nxt = b2_r;
    t_nxt = t_r;
    tmp_nxt = tmp_r;
    d_nxt = d_r;
    num_nxt = num_r;
    den_nxt = den_r;
    tz_nxt = tz_r;
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    status_nxt = status_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    mul_p_nxt = mul_p_r;
    dv_mag_nxt = dv_mag_r;
    dv_rem_nxt = dv_rem_r;
    dv_q_nxt = dv_q_r;
    dv_big_nxt = dv_big_r;
    dv_neg_nxt = dv_neg_r;
    dv_cnt_nxt = dv_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptls_pkg::CFG_FOCAL_X:  fx_nxt = cfg_data;
        ptls_pkg::CFG_FOCAL_Y:  fy_nxt = cfg_data;
        ptls_pkg::CFG_CENTER_X: cx_nxt = cfg_data;
        ptls_pkg::CFG_CENTER_Y: cy_nxt = cfg_data;
        default: fx_nxt = fx_r;
      endcase
    end

    if (sa_en) sums_nxt[sa_idx] = sa_res;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.func == ptls_pkg::FUNC_ROT) begin
            // row index 3 is dropped
            case (in_data.rot_row)
              2'd0: begin
                rot_nxt[0] = in_data.rot_c0;
                rot_nxt[1] = in_data.rot_c1;
                rot_nxt[2] = in_data.rot_c2;
              end
              2'd1: begin
                rot_nxt[3] = in_data.rot_c0;
                rot_nxt[4] = in_data.rot_c1;
                rot_nxt[5] = in_data.rot_c2;
              end
              2'd2: begin
                rot_nxt[6] = in_data.rot_c0;
                rot_nxt[7] = in_data.rot_c1;
                rot_nxt[8] = in_data.rot_c2;
              end
              default: rot_nxt = rot_r;
            endcase
          end else begin
            ox_nxt = in_data.obj_x;
            oy_nxt = in_data.obj_y;
            oz_nxt = in_data.obj_z;
            u_nxt = $signed({1'b0, in_data.img_u}) - $signed({1'b0, cx_r});
            v_nxt = $signed({1'b0, in_data.img_v}) - $signed({1'b0, cy_r});
            last_nxt = in_data.last;
            if (cnt_r < CW'(MAX_LANDMARKS)) begin
              op_nxt = ptls_pkg::OP_R0;
              st_nxt = ST_MUL_LD;
            end else begin
              st_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_MUL_LD: begin
        // sign of b moves onto a so the running sum stays two's complement
        mul_a_nxt = mul_b_s[63] ? (128'd0 - a128) : a128;
        mul_b_nxt = mul_b_s[63] ? (64'd0 - mul_b_s) : mul_b_s;
        mul_p_nxt = '0;
        st_nxt = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        if (mul_b_r == '0) begin
          st_nxt = ST_POST;
        end else begin
          if (mul_b_r[0]) mul_p_nxt = mul_p_r + mul_a_r;
          mul_a_nxt = {mul_a_r[126:0], 1'b0};
          mul_b_nxt = {1'b0, mul_b_r[63:1]};
        end
      end
      ST_POST: begin
        op_nxt = ptls_pkg::op_t'(op_r + ptls_pkg::OP_W'(1));
        st_nxt = ST_MUL_LD;
        case (op_r)
          ptls_pkg::OP_R0, ptls_pkg::OP_R1, ptls_pkg::OP_R3,
          ptls_pkg::OP_R4, ptls_pkg::OP_R6, ptls_pkg::OP_R7: acc_nxt = acc_sum;
          ptls_pkg::OP_R2: px_nxt = rnd[33:14];
          ptls_pkg::OP_R5: py_nxt = rnd[33:14];
          ptls_pkg::OP_R8: pz_nxt = rnd[33:14];
          ptls_pkg::OP_B1_A: b1_nxt = r64;
          ptls_pkg::OP_B1_B: b1_nxt = b1_r - r64;
          ptls_pkg::OP_B2_A: b2_nxt = r64;
          ptls_pkg::OP_B2_B: b2_nxt = b2_r - r64;
          ptls_pkg::OP_UB1: t_nxt = r64;
          ptls_pkg::OP_VB2: t_nxt = t_r + r64;
          ptls_pkg::OP_S5: begin
            cnt_nxt = cnt_r + CW'(1);
            st_nxt = ST_CHECK;
          end
          ptls_pkg::OP_D_SUM: tmp_nxt = s2 + s3;
          ptls_pkg::OP_D_N: d_nxt = r64;
          ptls_pkg::OP_D_U: d_nxt = d_tmp;
          ptls_pkg::OP_D_V: begin
            d_nxt = d_tmp;
            if (d_tmp <= 64'sd0) begin
              status_nxt = ptls_pkg::STATUS_SINGULAR;
              st_nxt = ST_OUT;
            end
          end
          ptls_pkg::OP_NZ_U: num_nxt = mul_p_r;
          ptls_pkg::OP_NZ_V: num_nxt = num_r + mul_p_r;
          ptls_pkg::OP_NZ_N: begin
            // op stays put so the divider knows which quotient it made
            op_nxt = op_r;
            num_nxt = num_r - mul_p_r;
            den_nxt = d_r;
            st_nxt = ST_DIV_NEG;
          end
          ptls_pkg::OP_X_T: num_nxt = 128'(s4) + mul_p_r;
          ptls_pkg::OP_Y_T: num_nxt = 128'(s5) + mul_p_r;
          ptls_pkg::OP_X_D, ptls_pkg::OP_Y_D: begin
            op_nxt = op_r;
            den_nxt = r64;
            st_nxt = ST_DIV_NEG;
          end
          default: op_nxt = ptls_pkg::op_t'(op_r + ptls_pkg::OP_W'(1));
        endcase
      end
      ST_CHECK: begin
        status_nxt = ptls_pkg::STATUS_OK;
        if (!last_r) begin
          st_nxt = ST_IDLE;
        end else if (cnt_r < CW'(ptls_pkg::MIN_POINTS)) begin
          status_nxt = ptls_pkg::STATUS_FEW;
          st_nxt = ST_OUT;
        end else if (fx_r == '0 || fy_r == '0) begin
          status_nxt = ptls_pkg::STATUS_SINGULAR;
          st_nxt = ST_OUT;
        end else begin
          op_nxt = ptls_pkg::OP_D_SUM;
          st_nxt = ST_MUL_LD;
        end
      end
      ST_DIV_NEG: begin
        dv_neg_nxt = num_r[127];
        dv_mag_nxt = num_r[127] ? (128'd0 - num_r) : num_r;
        st_nxt = ST_DIV_PRE;
      end
      ST_DIV_PRE: begin
        // twice the numerator plus the divisor gives half-away rounding
        dv_mag_nxt = {dv_mag_r[126:0], 1'b0} + {{64{den_r[63]}}, den_r};
        dv_rem_nxt = '0;
        dv_q_nxt = '0;
        dv_big_nxt = 1'b0;
        dv_cnt_nxt = '0;
        st_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        dv_mag_nxt = {dv_mag_r[126:0], 1'b0};
        if (|dv_q_r[63:40]) dv_big_nxt = 1'b1;
        if (rem_sh >= dv_den) begin
          dv_rem_nxt = rem_sh - dv_den;
          dv_q_nxt = {dv_q_r[62:0], 1'b1};
        end else begin
          dv_rem_nxt = rem_sh;
          dv_q_nxt = {dv_q_r[62:0], 1'b0};
        end
        dv_cnt_nxt = dv_cnt_r + ptls_pkg::DIV_CNT_W'(1);
        if (dv_cnt_r == ptls_pkg::DIV_CNT_W'(ptls_pkg::DIV_STEPS - 1)) st_nxt = ST_DIV_POST;
      end
      ST_DIV_POST: begin
        case (op_r)
          ptls_pkg::OP_NZ_N: begin
            if (dv_res <= 32'sd0) begin
              tz_nxt = '0;
              status_nxt = ptls_pkg::STATUS_BEHIND;
              st_nxt = ST_OUT;
            end else begin
              tz_nxt = dv_res;
              op_nxt = ptls_pkg::OP_X_T;
              st_nxt = ST_MUL_LD;
            end
          end
          ptls_pkg::OP_X_D: begin
            tx_nxt = dv_res;
            op_nxt = ptls_pkg::OP_Y_T;
            st_nxt = ST_MUL_LD;
          end
          default: begin
            ty_nxt = dv_res;
            st_nxt = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (status_r == ptls_pkg::STATUS_OK) begin
            out_data_nxt.trans_x = tx_r;
            out_data_nxt.trans_y = ty_r;
            out_data_nxt.trans_z = tz_r;
          end else begin
            out_data_nxt.trans_x = '0;
            out_data_nxt.trans_y = '0;
            out_data_nxt.trans_z = '0;
          end
          out_data_nxt.status = status_r;
          out_data_nxt.points_used = ptls_pkg::PU_W'(cnt_r);
          cnt_nxt = '0;
          for (int i = 0; i < ptls_pkg::NUM_SUMS; i++) sums_nxt[i] = '0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      op_r <= ptls_pkg::OP_R0;
      cnt_r <= '0;
      for (int i = 0; i < ptls_pkg::NUM_SUMS; i++) sums_r[i] <= '0;
      for (int i = 0; i < 9; i++) rot_r[i] <= '0;
      fx_r <= ptls_pkg::FOCAL_X_RST;
      fy_r <= ptls_pkg::FOCAL_Y_RST;
      cx_r <= ptls_pkg::CENTER_X_RST;
      cy_r <= ptls_pkg::CENTER_Y_RST;
      status_r <= ptls_pkg::STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
      cnt_r <= cnt_nxt;
      sums_r <= sums_nxt;
      rot_r <= rot_nxt;
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      status_r <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    oz_r <= oz_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
    last_r <= last_nxt;
    acc_r <= acc_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    pz_r <= pz_nxt;
    b1_r <= b1_nxt;
    b2_r <= b2_nxt;
    t_r <= t_nxt;
    tmp_r <= tmp_nxt;
    d_r <= d_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    tz_r <= tz_nxt;
    tx_r <= tx_nxt;
    ty_r <= ty_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    mul_p_r <= mul_p_nxt;
    dv_mag_r <= dv_mag_nxt;
    dv_rem_r <= dv_rem_nxt;
    dv_q_r <= dv_q_nxt;
    dv_big_r <= dv_big_nxt;
    dv_neg_r <= dv_neg_nxt;
    dv_cnt_r <= dv_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // multiplier consumes one bit of b per cycle
  a_mul_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MUL_RUN && mul_b_r != '0) |=> (mul_b_r == {1'b0, $past(mul_b_r[63:1])}))
    else $error("multiplier operand did not shift");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LANDMARKS))
    else $error("landmark count past limit");

  a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ptls_pkg::STATUS_OK) |-> (out_data_r.trans_z > 32'sd0))
    else $error("ok result with non-positive depth");

  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (cnt_r == '0 && sums_r[ptls_pkg::SUM_U] == '0))
    else $error("sums not cleared after solve");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;

  localparam int LANDMARK_CAP = 256;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 2000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ptls_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  ptls_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  pose_translation_least_squares_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic signed [15:0] rot_q14 [9];
  int lmk_count;
  longint nsum [7];
  longint reg_fx, reg_fy, reg_cx, reg_cy;

  ptls_pkg::out_item_t pose_expected [$];
  int mismatches;
  int errors;
  int cycle_count;
  bit quiet;

  function automatic longint turn_row(int row, longint x, longint y, longint z);
    longint p;
    p = longint'(rot_q14[row*3]) * x + longint'(rot_q14[row*3+1]) * y
      + longint'(rot_q14[row*3+2]) * z;
    return (p + 8192) >>> 14;
  endfunction

  function automatic void sat_add(int k, longint t);
    logic signed [64:0] s;
    s = 65'(nsum[k]) + 65'(t);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) nsum[k] = 64'h7fff_ffff_ffff_ffff;
    else if (s < -65'sh0_8000_0000_0000_0000) nsum[k] = 64'h8000_0000_0000_0000;
    else nsum[k] = s[63:0];
  endfunction

  // round half away from zero, saturate to 32 bits
  function automatic logic signed [31:0] div_round(logic signed [127:0] num, logic [63:0] den);
    logic neg;
    logic [127:0] mag;
    logic [129:0] m, q;
    neg = num[127];
    mag = neg ? -num : num;
    m = {1'b0, mag, 1'b0} + 130'(den);
    q = m / {65'd0, den, 1'b0};
    if (neg) return (q > 130'd2147483648) ? ptls_pkg::INT32_MIN : -q[31:0];
    return (q > 130'd2147483647) ? ptls_pkg::INT32_MAX : q[31:0];
  endfunction

  function automatic ptls_pkg::out_item_t solve_translation();
    ptls_pkg::out_item_t r;
    longint n, d;
    logic signed [127:0] su, sv, nz, tz;
    r = '0;
    n = lmk_count;
    su = nsum[0];
    sv = nsum[1];
    r.status = ptls_pkg::STATUS_OK;
    if (n < 3) r.status = ptls_pkg::STATUS_FEW;
    else if (reg_fx == 0 || reg_fy == 0) r.status = ptls_pkg::STATUS_SINGULAR;
    else begin
      d = n * (nsum[2] + nsum[3]) - nsum[0] * nsum[0] - nsum[1] * nsum[1];
      if (d <= 0) r.status = ptls_pkg::STATUS_SINGULAR;
      else begin
        nz = su * 128'(nsum[4]) + sv * 128'(nsum[5]) - 128'(n) * 128'(nsum[6]);
        r.trans_z = div_round(nz, d);
        if (r.trans_z <= 0) begin
          r.status = ptls_pkg::STATUS_BEHIND;
          r.trans_z = 0;
        end else begin
          tz = r.trans_z;
          r.trans_x = div_round(128'(nsum[4]) + su * tz, n * reg_fx);
          r.trans_y = div_round(128'(nsum[5]) + sv * tz, n * reg_fy);
        end
      end
    end
    r.points_used = lmk_count[ptls_pkg::PU_W-1:0];
    return r;
  endfunction

  function automatic void predict_item(ptls_pkg::in_item_t it);
    longint px, py, pz, u, v, b1, b2;
    if (it.func == ptls_pkg::FUNC_ROT) begin
      if (it.rot_row < 3) begin
        rot_q14[it.rot_row*3]   = it.rot_c0;
        rot_q14[it.rot_row*3+1] = it.rot_c1;
        rot_q14[it.rot_row*3+2] = it.rot_c2;
      end
      return;
    end
    if (lmk_count < LANDMARK_CAP) begin
      px = turn_row(0, it.obj_x, it.obj_y, it.obj_z);
      py = turn_row(1, it.obj_x, it.obj_y, it.obj_z);
      pz = turn_row(2, it.obj_x, it.obj_y, it.obj_z);
      u = longint'(it.img_u) - reg_cx;
      v = longint'(it.img_v) - reg_cy;
      b1 = u * pz - reg_fx * px;
      b2 = v * pz - reg_fy * py;
      sat_add(0, u);
      sat_add(1, v);
      sat_add(2, u * u);
      sat_add(3, v * v);
      sat_add(4, b1);
      sat_add(5, b2);
      sat_add(6, u * b1 + v * b2);
      lmk_count++;
    end
    if (it.last) begin
      pose_expected.push_back(solve_translation());
      for (int i = 0; i < 7; i++) nsum[i] = 0;
      lmk_count = 0;
    end
  endfunction

  function automatic ptls_pkg::in_item_t rot_beat(int row, int c0, int c1, int c2);
    ptls_pkg::in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, 4'($urandom)};
    it.func = ptls_pkg::FUNC_ROT;
    it.rot_row = row[1:0];
    it.rot_c0 = c0[15:0];
    it.rot_c1 = c1[15:0];
    it.rot_c2 = c2[15:0];
    return it;
  endfunction

  function automatic ptls_pkg::in_item_t lmk_beat(int x, int y, int z, int u, int v, bit lst);
    ptls_pkg::in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, 4'($urandom)};
    it.func = ptls_pkg::FUNC_LMK;
    it.obj_x = x[15:0];
    it.obj_y = y[15:0];
    it.obj_z = z[15:0];
    it.img_u = u[15:0];
    it.img_v = v[15:0];
    it.last = lst;
    return it;
  endfunction

  function automatic int clamp16(longint a);
    return (a < 0) ? 0 : (a > 65535) ? 65535 : int'(a);
  endfunction

  // landmark seen through the loaded rotation from a given translation
  function automatic ptls_pkg::in_item_t projected_beat(longint tx, longint ty, longint tz,
                                                        bit mirror, bit lst);
    int x, y, z;
    longint cx, cy, cz, u, v;
    x = $urandom_range(0, 8000) - 4000;
    y = $urandom_range(0, 8000) - 4000;
    z = $urandom_range(0, 8000) - 4000;
    cx = turn_row(0, x, y, z) + tx;
    cy = turn_row(1, x, y, z) + ty;
    cz = turn_row(2, x, y, z) + tz;
    if (cz < 1) cz = 1;
    u = reg_fx * cx / cz + longint'($urandom_range(0, 6)) - 3;
    v = reg_fy * cy / cz + longint'($urandom_range(0, 6)) - 3;
    if (mirror) begin
      u = -u;
      v = -v;
    end
    return lmk_beat(x, y, z, clamp16(reg_cx + u), clamp16(reg_cy + v), lst);
  endfunction

  task automatic send(ptls_pkg::in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  // drain all results and let the last landmark finish before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_expected.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(ptls_pkg::cfg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ptls_pkg::CFG_FOCAL_X:  reg_fx = value & 16'hffff;
      ptls_pkg::CFG_FOCAL_Y:  reg_fy = value & 16'hffff;
      ptls_pkg::CFG_CENTER_X: reg_cx = value & 16'hffff;
      default:                reg_cy = value & 16'hffff;
    endcase
  endtask

  task automatic load_identity();
    send(rot_beat(0, 16384, 0, 0));
    send(rot_beat(1, 0, 16384, 0));
    send(rot_beat(2, 0, 0, 16384));
  endtask

  task automatic load_random_rotation();
    for (int r = 0; r < 3; r++)
      send(rot_beat(r, $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384));
  endtask

  task automatic send_pose_set(int count, bit mirror);
    longint tx, ty, tz;
    tx = longint'($urandom_range(0, 20000)) - 10000;
    ty = longint'($urandom_range(0, 20000)) - 10000;
    tz = $urandom_range(40000, 200000);
    for (int i = 0; i < count; i++) send(projected_beat(tx, ty, tz, mirror, i == count - 1));
  endtask

  task automatic test_special_cases();
    load_identity();
    // a bad row must leave the identity untouched
    send(rot_beat(3, -16384, 16384, -16384));
    send_pose_set(6, 1'b0);
    send_pose_set(5, 1'b1);
    send(lmk_beat(100, 200, 300, 20000, 9000, 1'b0));
    send(lmk_beat(100, 200, 300, 20000, 9000, 1'b1));
    send(lmk_beat(0, 0, 0, 0, 0, 1'b1));
    for (int i = 0; i < 4; i++) send(lmk_beat(64, -64, 128, 5000, 5000, i == 3));
  endtask

  task automatic test_field_extremes();
    send(rot_beat(0, -16384, 16384, -16384));
    send(rot_beat(1, 16384, -16384, 16384));
    send(rot_beat(2, 16384, 16384, 16384));
    send(lmk_beat(-32768, 32767, -32768, 0, 65535, 1'b0));
    send(lmk_beat(32767, -32768, 32767, 65535, 0, 1'b0));
    send(lmk_beat(32767, 32767, 32767, 65535, 65535, 1'b0));
    send(lmk_beat(-32768, -32768, -32768, 0, 0, 1'b1));
  endtask

  task automatic test_register_extremes();
    int fx_set [4] = '{1, 65535, 16384, 700};
    int cx_set [4] = '{0, 65535, 10240, 31000};
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_reg(ptls_pkg::CFG_FOCAL_X, fx_set[k]);
      write_reg(ptls_pkg::CFG_FOCAL_Y, fx_set[3-k]);
      write_reg(ptls_pkg::CFG_CENTER_X, cx_set[k]);
      write_reg(ptls_pkg::CFG_CENTER_Y, cx_set[(k+1)%4]);
      load_identity();
      send_pose_set(4, 1'b0);
      load_random_rotation();
      send_pose_set(3, 1'b0);
    end
  endtask

  task automatic test_full_set();
    wait_idle();
    write_reg(ptls_pkg::CFG_FOCAL_X, 16384);
    write_reg(ptls_pkg::CFG_FOCAL_Y, 15000);
    write_reg(ptls_pkg::CFG_CENTER_X, 10240);
    write_reg(ptls_pkg::CFG_CENTER_Y, 7680);
    load_identity();
    send_pose_set(LANDMARK_CAP + 4, 1'b0);
  endtask

  task automatic test_random_sets(int budget);
    int sent;
    int n;
    ptls_pkg::in_item_t junk;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
        write_reg(ptls_pkg::CFG_FOCAL_X, $urandom_range(200, 65535));
        write_reg(ptls_pkg::CFG_FOCAL_Y, $urandom_range(200, 65535));
        write_reg(ptls_pkg::CFG_CENTER_X, $urandom_range(0, 65535));
        write_reg(ptls_pkg::CFG_CENTER_Y, $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 2) == 0) begin
        load_random_rotation();
        sent += 3;
      end
      case ($urandom_range(0, 9))
        0: begin
          // noise: random beats of any kind
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            junk = {$urandom, $urandom, $urandom, $urandom, 4'($urandom)};
            send(junk);
          end
          sent += n;
        end
        1: begin
          n = $urandom_range(1, 2);
          send_pose_set(n, 1'b0);
          sent += n;
        end
        2: begin
          n = $urandom_range(3, 10);
          send_pose_set(n, 1'b1);
          sent += n;
        end
        default: begin
          n = $urandom_range(3, 12);
          send_pose_set(n, 1'b0);
          sent += n;
        end
      endcase
    end
  endtask

  // result check
  always @(posedge clk) begin
    ptls_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_expected.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected pose result %p", out_data);
      end else begin
        want = pose_expected.pop_front();
        if (out_data.trans_x !== want.trans_x || out_data.trans_y !== want.trans_y ||
            out_data.trans_z !== want.trans_z || out_data.status !== want.status ||
            out_data.points_used !== want.points_used) begin
          errors++;
          if (mismatches++ < 10)
            $display("pose mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  // result side stalls
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ptls_pkg::CFG_FOCAL_X;
    cfg_data = '0;
    quiet = 1'b0;
    for (int i = 0; i < 9; i++) rot_q14[i] = 0;
    for (int i = 0; i < 7; i++) nsum[i] = 0;
    lmk_count = 0;
    reg_fx = ptls_pkg::FOCAL_X_RST;
    reg_fy = ptls_pkg::FOCAL_Y_RST;
    reg_cx = ptls_pkg::CENTER_X_RST;
    reg_cy = ptls_pkg::CENTER_Y_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_field_extremes();
    test_register_extremes();
    test_full_set();
    test_random_sets(280);
    quiet = 1'b1;
    test_random_sets(100);

    in_valid <= 1'b0;
    while (pose_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
